@@ src/ecam_pkg.sv @@
package ecam_pkg;

  // Angle limits, 1/128 degree
  localparam int ANG_HALF    = 23040;
  localparam int ANG_FULL    = 46080;
  localparam int ANG_QUARTER = 11520;
  localparam int PITCH_LIM   = 11392;

  // Zoom limits, 1/16 degree
  localparam int ZOOM_MIN = 16;
  localparam int ZOOM_MAX = 720;

  // CORDIC
  localparam int ECAM_CORDIC_STEPS = 16;
  localparam int ATAN_IW           = 5;
  localparam int CORDIC_GAIN       = 652032874;

  // Root / divide unit
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;

  // Request codes
  localparam logic [1:0] REQ_MOVE   = 2'd0;
  localparam logic [1:0] REQ_SCROLL = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;

  // Register indexes
  localparam logic [2:0] CFG_SENS   = 3'd0;
  localparam logic [2:0] CFG_WUP_X  = 3'd1;
  localparam logic [2:0] CFG_WUP_Y  = 3'd2;
  localparam logic [2:0] CFG_WUP_Z  = 3'd3;
  localparam logic [2:0] CFG_SYAW   = 3'd4;
  localparam logic [2:0] CFG_SPITCH = 3'd5;
  localparam logic [2:0] CFG_SZOOM  = 3'd6;

  // Command to the root / divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } ecam_cmd_t;

  // arctan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_val(input logic [ATAN_IW-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/ecam_sqdiv.sv @@
// Shared compare-subtract unit: integer square root (2 bits a step)
// or restoring divide (one quotient bit a step).
module ecam_sqdiv import ecam_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ecam_cmd_t   cmd,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic        done,
  output logic [31:0] res
);

  logic        busy;
  logic        isdiv;
  logic [4:0]  cnt;
  logic [63:0] acc;
  logic [63:0] root;
  logic [63:0] bitm;
  logic [63:0] trial;
  logic [63:0] diff;
  logic        ge;

  // one compare and subtract per cycle
  assign trial = isdiv ? bitm : root + bitm;
  assign ge    = (acc >= trial);
  assign diff  = acc - trial;
  assign res   = root[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        isdiv <= cmd.is_div;
        acc   <= opa;
        root  <= '0;
        if (cmd.is_div) begin
          bitm <= opb << (DIV_STEPS - 1);
          cnt  <= 5'(DIV_STEPS - 1);
        end else begin
          bitm <= 64'h4000_0000_0000_0000;
          cnt  <= 5'(SQRT_STEPS - 1);
        end
      end else if (busy) begin
        if (ge) acc <= diff;
        if (isdiv) begin
          root <= {root[62:0], ge};
          bitm <= bitm >> 1;
        end else begin
          root <= ge ? (root >> 1) + bitm : root >> 1;
          bitm <= bitm >> 2;
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule

@@ src/euler_camera_orientation.sv @@
// Channel   Signals                                          Direction
// input     in_valid/in_ready, req_type, delta_x, delta_y,   in
//           constrain_pitch
// result    out_valid/out_ready, front_*, right_*, up_*,     out
//           zoom_now, pitch_now, degenerate
// config    cfg_valid/cfg_ready, cfg_index, cfg_data         in
//
// A move or load item wraps its angles into range, then runs two CORDIC runs, then
// three normalizations, each held by the shared square-root/divide unit (32 root
// steps, 15 divide steps per component). A degenerate basis ends sooner. Scroll
// and unknown items go straight to the result. One item at a time; in_ready and
// cfg_ready are high only when idle.
// After reset the basis is rebuilt for the reset pose (no item). A result waits in
// the output registers; a stalled output holds the sequencer at its last step.
module euler_camera_orientation import ecam_pkg::*; #(
  parameter int CORDIC_STEPS = ECAM_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [11:0] delta_x,
  input  logic signed [11:0] delta_y,
  input  logic               constrain_pitch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] front_x,
  output logic signed [15:0] front_y,
  output logic signed [15:0] front_z,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic signed [15:0] right_z,
  output logic signed [15:0] up_x,
  output logic signed [15:0] up_y,
  output logic signed [15:0] up_z,
  output logic [9:0]         zoom_now,
  output logic signed [15:0] pitch_now,
  output logic               degenerate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_MOVE_X     = 5'd1;
  localparam logic [4:0] S_MOVE_Y     = 5'd2;
  localparam logic [4:0] S_WRAP_YAW   = 5'd3;
  localparam logic [4:0] S_WRAP_PITCH = 5'd4;
  localparam logic [4:0] S_CS_INIT    = 5'd5;
  localparam logic [4:0] S_CS_ITER    = 5'd6;
  localparam logic [4:0] S_CS_DONE    = 5'd7;
  localparam logic [4:0] S_FRONT0     = 5'd8;
  localparam logic [4:0] S_FRONT1     = 5'd9;
  localparam logic [4:0] S_FRONT2     = 5'd10;
  localparam logic [4:0] S_SQ         = 5'd11;
  localparam logic [4:0] S_SQ_ACC     = 5'd12;
  localparam logic [4:0] S_SQRT       = 5'd13;
  localparam logic [4:0] S_SQRT_WAIT  = 5'd14;
  localparam logic [4:0] S_DIV        = 5'd15;
  localparam logic [4:0] S_DIV_WAIT   = 5'd16;
  localparam logic [4:0] S_NORM_RET   = 5'd17;
  localparam logic [4:0] S_CROSS      = 5'd18;
  localparam logic [4:0] S_CROSS_ACC  = 5'd19;
  localparam logic [4:0] S_FINISH     = 5'd20;

  localparam logic [1:0] VSEL_FRONT = 2'd0;
  localparam logic [1:0] VSEL_RIGHT = 2'd1;
  localparam logic [1:0] VSEL_UP    = 2'd2;

  logic [4:0] state;

  // configuration
  logic [15:0]        sens;
  logic signed [15:0] wu [3];
  logic signed [15:0] syaw;
  logic signed [14:0] spitch;
  logic [9:0]         szoom;

  // pose
  logic signed [15:0] yaw;
  logic signed [15:0] pitch;
  logic [9:0]         zoom;
  logic signed [15:0] bf [3];
  logic signed [15:0] br [3];
  logic signed [15:0] bu [3];
  logic               degen;

  // item
  logic [1:0]         req_q;
  logic signed [11:0] dx_q;
  logic signed [11:0] dy_q;
  logic               cons_q;
  logic               emit;

  // work registers
  logic signed [20:0] acc;
  logic               phase;
  logic               neg;
  logic [ATAN_IW-1:0] iter;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [24:0] cz;
  logic signed [31:0] syw;
  logic signed [31:0] cyw;
  logic signed [31:0] spt;
  logic signed [31:0] cpt;
  logic signed [31:0] vec [3];
  logic [63:0]        nacc;
  logic [31:0]        len;
  logic [1:0]         k;
  logic               h;
  logic [1:0]         nsel;
  logic               nok;

  // shared multiplier
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;
  logic               mul_en;

  // root / divide unit
  ecam_cmd_t   cmd;
  logic [63:0] opa;
  logic [63:0] opb;
  logic        sd_done;
  logic [31:0] sd_res;

  ecam_sqdiv u_sqdiv (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .opa  (opa),
    .opb  (opb),
    .done (sd_done),
    .res  (sd_res)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // result registers load when the item ends and the output is free
  logic out_load;
  assign out_load = (state == S_FINISH) && emit && (!out_valid || out_ready);

  // rounded angle step from delta * sensitivity
  logic signed [28:0] drnd;
  logic signed [19:0] delta;
  assign drnd  = $signed(prod[28:0]) + 29'sd256;
  assign delta = drnd[28:9];

  // scroll zoom
  logic signed [16:0] zsc;
  assign zsc = $signed({7'b0, zoom}) - $signed({{1{delta_y[11]}}, delta_y, 4'b0});

  // angle fold into [-90,90]
  logic signed [15:0] ang;
  logic signed [15:0] fang;
  logic               fneg;
  always_comb begin
    ang  = phase ? pitch : yaw;
    fang = ang;
    fneg = 1'b0;
    if (ang > 16'sd11520) begin
      fang = ang - 16'sd23040;
      fneg = 1'b1;
    end else if (ang < -16'sd11520) begin
      fang = ang + 16'sd23040;
      fneg = 1'b1;
    end
  end

  // CORDIC shifted terms
  logic signed [31:0] xsh;
  logic signed [31:0] ysh;
  logic signed [24:0] atn;
  assign xsh = cx >>> iter;
  assign ysh = cy >>> iter;
  assign atn = $signed({3'b0, atan_val(iter)});

  // cross product operand indexes
  function automatic logic [1:0] nxt(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction
  logic [1:0]         ia;
  logic [1:0]         ib;
  logic [1:0]         fidx;
  logic [1:0]         oidx;
  logic signed [15:0] fsel;
  logic signed [15:0] osel;
  logic signed [15:0] xa;
  logic signed [15:0] xb;
  always_comb begin
    ia   = h ? nxt(nxt(k)) : nxt(k);
    ib   = h ? nxt(k) : nxt(nxt(k));
    fidx = (nsel == VSEL_RIGHT) ? ia : ib;
    oidx = (nsel == VSEL_RIGHT) ? ib : ia;
    fsel = bf[fidx];
    osel = (nsel == VSEL_RIGHT) ? wu[oidx] : br[oidx];
    xa   = (nsel == VSEL_RIGHT) ? fsel : osel;
    xb   = (nsel == VSEL_RIGHT) ? osel : fsel;
  end

  // component magnitude and quotient sign
  logic signed [31:0] vk;
  logic [31:0]        mabs;
  logic signed [15:0] qs;
  assign vk   = vec[k];
  assign mabs = vk[31] ? 32'(-vk) : 32'(vk);
  assign qs   = vk[31] ? -$signed(sd_res[15:0]) : $signed(sd_res[15:0]);

  // multiplier operand select
  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    case (state)
      S_MOVE_X: begin
        ma = 33'(dx_q);
        mb = $signed({17'b0, sens});
      end
      S_MOVE_Y: begin
        ma = 33'(dy_q);
        mb = $signed({17'b0, sens});
      end
      S_FRONT0: begin
        ma = 33'(cyw);
        mb = 33'(cpt);
      end
      S_FRONT1: begin
        ma = 33'(syw);
        mb = 33'(cpt);
      end
      S_SQ: begin
        ma = 33'(vk);
        mb = 33'(vk);
      end
      S_CROSS: begin
        ma = 33'(xa);
        mb = 33'(xb);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // root / divide commands
  always_comb begin
    cmd.start  = (state == S_SQRT) || (state == S_DIV);
    cmd.is_div = (state == S_DIV);
    opa        = (state == S_DIV) ? (64'(mabs) << 15) + 64'(len) : nacc;
    opb        = 64'(len) << 1;
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= ma * mb;
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CS_INIT;
      phase     <= 1'b0;
      emit      <= 1'b0;
      sens      <= 16'd6554;
      wu[0]     <= 16'sd0;
      wu[1]     <= 16'sd16384;
      wu[2]     <= 16'sd0;
      syaw      <= -16'sd11520;
      spitch    <= 15'sd0;
      szoom     <= 10'd720;
      yaw       <= -16'sd11520;
      pitch     <= 16'sd0;
      zoom      <= 10'd720;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SENS:   sens   <= cfg_data;
          CFG_WUP_X:  wu[0]  <= cfg_data;
          CFG_WUP_Y:  wu[1]  <= cfg_data;
          CFG_WUP_Z:  wu[2]  <= cfg_data;
          CFG_SYAW:   syaw   <= cfg_data;
          CFG_SPITCH: spitch <= cfg_data[14:0];
          CFG_SZOOM:  szoom  <= cfg_data[9:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q  <= req_type;
            dx_q   <= delta_x;
            dy_q   <= delta_y;
            cons_q <= constrain_pitch;
            emit   <= 1'b1;
            case (req_type)
              REQ_MOVE: state <= S_MOVE_X;
              REQ_SCROLL: begin
                if (zsc < 17'sd16) zoom <= 10'd16;
                else if (zsc > 17'sd720) zoom <= 10'd720;
                else zoom <= zsc[9:0];
                state <= S_FINISH;
              end
              REQ_LOAD: begin
                acc <= 21'(syaw);
                if (szoom < 10'd16) zoom <= 10'd16;
                else if (szoom > 10'd720) zoom <= 10'd720;
                else zoom <= szoom;
                state <= S_WRAP_YAW;
              end
              default: state <= S_FINISH;
            endcase
          end
        end

        S_MOVE_X: state <= S_MOVE_Y;

        S_MOVE_Y: begin
          acc   <= 21'(yaw) + 21'(delta);
          state <= S_WRAP_YAW;
        end

        // wrap yaw one period a cycle
        S_WRAP_YAW: begin
          if (acc >= 21'sd23040) acc <= acc - 21'sd46080;
          else if (acc < -21'sd23040) acc <= acc + 21'sd46080;
          else begin
            yaw <= acc[15:0];
            if (req_q == REQ_LOAD) acc <= 21'(spitch);
            else acc <= 21'(pitch) + 21'(delta);
            state <= S_WRAP_PITCH;
          end
        end

        // clamp or wrap pitch
        S_WRAP_PITCH: begin
          if (req_q == REQ_MOVE && cons_q) begin
            if (acc > 21'sd11392) pitch <= 16'sd11392;
            else if (acc < -21'sd11392) pitch <= -16'sd11392;
            else pitch <= acc[15:0];
            phase <= 1'b0;
            state <= S_CS_INIT;
          end else if (acc >= 21'sd23040) acc <= acc - 21'sd46080;
          else if (acc < -21'sd23040) acc <= acc + 21'sd46080;
          else begin
            pitch <= acc[15:0];
            phase <= 1'b0;
            state <= S_CS_INIT;
          end
        end

        S_CS_INIT: begin
          cx    <= 32'(CORDIC_GAIN);
          cy    <= '0;
          cz    <= {fang, 9'b0};
          neg   <= fneg;
          iter  <= '0;
          state <= S_CS_ITER;
        end

        // one rotation a cycle
        S_CS_ITER: begin
          if (!cz[24]) begin
            cx <= cx - ysh;
            cy <= cy + xsh;
            cz <= cz - atn;
          end else begin
            cx <= cx + ysh;
            cy <= cy - xsh;
            cz <= cz + atn;
          end
          if (iter == ATAN_IW'(CORDIC_STEPS - 1)) state <= S_CS_DONE;
          else iter <= iter + 1'b1;
        end

        S_CS_DONE: begin
          if (!phase) begin
            syw   <= neg ? -cy : cy;
            cyw   <= neg ? -cx : cx;
            phase <= 1'b1;
            state <= S_CS_INIT;
          end else begin
            spt   <= neg ? -cy : cy;
            cpt   <= neg ? -cx : cx;
            state <= S_FRONT0;
          end
        end

        S_FRONT0: state <= S_FRONT1;

        S_FRONT1: begin
          vec[0] <= prod[61:30];
          state  <= S_FRONT2;
        end

        S_FRONT2: begin
          vec[2] <= prod[61:30];
          vec[1] <= spt;
          nsel   <= VSEL_FRONT;
          nacc   <= '0;
          k      <= 2'd0;
          state  <= S_SQ;
        end

        // sum of squares
        S_SQ: state <= S_SQ_ACC;

        S_SQ_ACC: begin
          nacc <= nacc + prod[63:0];
          if (k == 2'd2) begin
            k     <= 2'd0;
            state <= S_SQRT;
          end else begin
            k     <= k + 2'd1;
            state <= S_SQ;
          end
        end

        S_SQRT: state <= S_SQRT_WAIT;

        S_SQRT_WAIT: begin
          if (sd_done) begin
            len <= sd_res;
            if (sd_res == 32'd0) begin
              nok <= 1'b0;
              case (nsel)
                VSEL_FRONT: begin
                  bf[0] <= '0; bf[1] <= '0; bf[2] <= '0;
                end
                VSEL_RIGHT: begin
                  br[0] <= '0; br[1] <= '0; br[2] <= '0;
                end
                default: begin
                  bu[0] <= '0; bu[1] <= '0; bu[2] <= '0;
                end
              endcase
              state <= S_NORM_RET;
            end else begin
              nok   <= 1'b1;
              k     <= 2'd0;
              state <= S_DIV;
            end
          end
        end

        S_DIV: state <= S_DIV_WAIT;

        S_DIV_WAIT: begin
          if (sd_done) begin
            case (nsel)
              VSEL_FRONT: bf[k] <= qs;
              VSEL_RIGHT: br[k] <= qs;
              default:    bu[k] <= qs;
            endcase
            if (k == 2'd2) state <= S_NORM_RET;
            else begin
              k     <= k + 2'd1;
              state <= S_DIV;
            end
          end
        end

        S_NORM_RET: begin
          k <= 2'd0;
          h <= 1'b0;
          case (nsel)
            VSEL_FRONT: begin
              nsel  <= VSEL_RIGHT;
              state <= S_CROSS;
            end
            VSEL_RIGHT: begin
              if (nok) begin
                degen <= 1'b0;
                nsel  <= VSEL_UP;
                state <= S_CROSS;
              end else begin
                degen <= 1'b1;
                bu[0] <= '0; bu[1] <= '0; bu[2] <= '0;
                state <= S_FINISH;
              end
            end
            default: state <= S_FINISH;
          endcase
        end

        // cross product, one term a pass
        S_CROSS: state <= S_CROSS_ACC;

        S_CROSS_ACC: begin
          if (!h) vec[k] <= prod[31:0];
          else vec[k] <= vec[k] - prod[31:0];
          h <= ~h;
          if (h) begin
            if (k == 2'd2) begin
              k     <= 2'd0;
              nacc  <= '0;
              state <= S_SQ;
            end else begin
              k     <= k + 2'd1;
              state <= S_CROSS;
            end
          end else begin
            state <= S_CROSS;
          end
        end

        S_FINISH: begin
          if (!emit) state <= S_IDLE;
          else if (out_load) begin
            front_x    <= bf[0];
            front_y    <= bf[1];
            front_z    <= bf[2];
            right_x    <= br[0];
            right_y    <= br[1];
            right_z    <= br[2];
            up_x       <= bu[0];
            up_y       <= bu[1];
            up_z       <= bu[2];
            zoom_now   <= zoom;
            pitch_now  <= pitch;
            degenerate <= degen;
            emit       <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // one item in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while busy");

  // pitch and zoom stay in range
  a_pose_range: assert property (@(posedge clk) disable iff (rst)
    pitch >= -16'sd23040 && pitch <= 16'sd23039 && zoom >= 10'd16 && zoom <= 10'd720)
    else $error("pitch or zoom out of range");

  // root/divide completes only when awaited
  a_sd_done: assert property (@(posedge clk) disable iff (rst)
    sd_done |-> state == S_SQRT_WAIT || state == S_DIV_WAIT)
    else $error("unexpected root/divide completion");

  // degenerate basis has zero right and up
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> right_x == 16'sd0 && right_y == 16'sd0 &&
      right_z == 16'sd0 && up_x == 16'sd0 && up_y == 16'sd0 && up_z == 16'sd0)
    else $error("degenerate result with nonzero right or up");

endmodule

@@ verif/ecam_checker.sv @@
`timescale 1ns / 1ps

// Watches the camera channels, predicts each result and compares it.
module ecam_checker import ecam_pkg::*; #(
  parameter int CORDIC_STEPS = ECAM_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [11:0] delta_x,
  input  logic signed [11:0] delta_y,
  input  logic               constrain_pitch,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] front_x,
  input  logic signed [15:0] front_y,
  input  logic signed [15:0] front_z,
  input  logic signed [15:0] right_x,
  input  logic signed [15:0] right_y,
  input  logic signed [15:0] right_z,
  input  logic signed [15:0] up_x,
  input  logic signed [15:0] up_y,
  input  logic signed [15:0] up_z,
  input  logic [9:0]         zoom_now,
  input  logic signed [15:0] pitch_now,
  input  logic               degenerate,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
    logic [9:0]         zoom;
    logic signed [15:0] pitch;
    logic               degen;
  } pose_t;

  // arctan(2^-i), 1/65536 degree
  longint arctan_q16 [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                              29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                              29, 14, 7, 4, 2, 1, 0};

  // Shadow registers
  logic [15:0]        sens_r;
  logic signed [15:0] wup_x_r, wup_y_r, wup_z_r;
  logic [15:0]        syaw_r;
  logic [14:0]        spitch_r;
  logic [9:0]         szoom_r;

  // Predicted state
  longint yaw_a, pitch_a, zoom_a;
  longint bas [9];
  bit     degen_a;
  pose_t  pose_q [$];
  int     fails;

  function automatic longint wrap_deg(input longint v);
    longint t;
    t = (v + ANG_HALF) % ANG_FULL;
    if (t < 0) t += ANG_FULL;
    return t - ANG_HALF;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Q2.30 sine/cosine by CORDIC, angle folded into +-90 degrees
  function automatic void sin_cos(input longint a, output longint s, output longint c);
    bit     flip;
    longint x, y, z, nx;
    flip = 0;
    x = CORDIC_GAIN;
    y = 0;
    if (a > ANG_QUARTER) begin a -= ANG_HALF; flip = 1; end
    if (a < -ANG_QUARTER) begin a += ANG_HALF; flip = 1; end
    z = a * 512;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= arctan_q16[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += arctan_q16[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scale_q14(input longint v, input longint unsigned len);
    longint unsigned m;
    longint q;
    m = (v < 0) ? -v : v;
    q = (m * 32768 + len) / (2 * len);
    return (v < 0) ? -q : q;
  endfunction

  // Unit vector in Q1.14; returns 0 for a zero vector
  function automatic bit unit(input longint x, y, z, output longint ox, oy, oz);
    longint unsigned len;
    len = int_root(x * x + y * y + z * z);
    ox = 0; oy = 0; oz = 0;
    if (len == 0) return 0;
    ox = scale_q14(x, len);
    oy = scale_q14(y, len);
    oz = scale_q14(z, len);
    return 1;
  endfunction

  // Front, right and up for the current angles
  function automatic void rebuild_basis();
    longint sy, cy, sp, cp, fx, fy, fz, rx, ry, rz, ux, uy, uz, wx, wy, wz, dummy;
    sin_cos(yaw_a, sy, cy);
    sin_cos(pitch_a, sp, cp);
    dummy = unit((cy * cp) >>> 30, sp, (sy * cp) >>> 30, fx, fy, fz);
    wx = wup_x_r; wy = wup_y_r; wz = wup_z_r;
    if (unit(fy * wz - fz * wy, fz * wx - fx * wz, fx * wy - fy * wx, rx, ry, rz)) begin
      degen_a = 0;
      dummy = unit(ry * fz - rz * fy, rz * fx - rx * fz, rx * fy - ry * fx, ux, uy, uz);
    end else begin
      degen_a = 1;
      ux = 0; uy = 0; uz = 0;
    end
    bas = '{fx, fy, fz, rx, ry, rz, ux, uy, uz};
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    pose_t p;
    longint sens, pt;
    if (rst) begin
      sens_r   <= 16'd6554;
      wup_x_r  <= 16'sd0;
      wup_y_r  <= 16'sd16384;
      wup_z_r  <= 16'sd0;
      syaw_r   <= 16'hD300;
      spitch_r <= '0;
      szoom_r  <= 10'd720;
      yaw_a    = -11520;
      pitch_a  = 0;
      zoom_a   = 720;
      pose_q.delete();
      fails    = 0;
    end else begin
      // results out
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          $error("result with no item outstanding");
          fails++;
        end else begin
          p = pose_q.pop_front();
          check_field("front_x", p.fx, front_x);
          check_field("front_y", p.fy, front_y);
          check_field("front_z", p.fz, front_z);
          check_field("right_x", p.rx, right_x);
          check_field("right_y", p.ry, right_y);
          check_field("right_z", p.rz, right_z);
          check_field("up_x", p.ux, up_x);
          check_field("up_y", p.uy, up_y);
          check_field("up_z", p.uz, up_z);
          check_field("zoom_now", p.zoom, zoom_now);
          check_field("pitch_now", p.pitch, pitch_now);
          check_field("degenerate", p.degen, degenerate);
        end
      end
      // items in
      if (in_valid && in_ready) begin
        sens = sens_r;
        if (req_type == REQ_MOVE) begin
          yaw_a = wrap_deg(yaw_a + ((longint'(delta_x) * sens + 256) >>> 9));
          pt = pitch_a + ((longint'(delta_y) * sens + 256) >>> 9);
          pitch_a = constrain_pitch ? clamp(pt, -PITCH_LIM, PITCH_LIM) : wrap_deg(pt);
          rebuild_basis();
        end else if (req_type == REQ_SCROLL) begin
          zoom_a = clamp(zoom_a - 16 * longint'(delta_y), ZOOM_MIN, ZOOM_MAX);
        end else if (req_type == REQ_LOAD) begin
          yaw_a   = wrap_deg(longint'($signed(syaw_r)));
          pitch_a = wrap_deg(longint'($signed(spitch_r)));
          zoom_a  = clamp(szoom_r, ZOOM_MIN, ZOOM_MAX);
          rebuild_basis();
        end
        p = '{bas[0], bas[1], bas[2], bas[3], bas[4], bas[5], bas[6], bas[7], bas[8],
              zoom_a, pitch_a, degen_a};
        pose_q.push_back(p);
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SENS:   sens_r   <= cfg_data;
          CFG_WUP_X:  wup_x_r  <= cfg_data;
          CFG_WUP_Y:  wup_y_r  <= cfg_data;
          CFG_WUP_Z:  wup_z_r  <= cfg_data;
          CFG_SYAW:   syaw_r   <= cfg_data;
          CFG_SPITCH: spitch_r <= cfg_data[14:0];
          CFG_SZOOM:  szoom_r  <= cfg_data[9:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending    <= pose_q.size();
  end

  // reset pose basis, rebuilt once the reset registers are in place
  always @(negedge rst) rebuild_basis();

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ecam_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [2:0] CFG_SPARE = 3'd7;
  localparam int LIMIT = 4000000;

  logic               clk, rst;
  logic               in_valid, in_ready;
  logic [1:0]         req_type;
  logic signed [11:0] delta_x, delta_y;
  logic               constrain_pitch;
  logic               out_valid, out_ready;
  logic signed [15:0] front_x, front_y, front_z, right_x, right_y, right_z;
  logic signed [15:0] up_x, up_y, up_z, pitch_now;
  logic [9:0]         zoom_now;
  logic               degenerate;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count, pending;
  int                 in_idle, out_idle;
  int                 cycles = 0;

  euler_camera_orientation u_top (.*);
  ecam_checker u_chk (.*);

  // 2 ns clock
  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= out_idle);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] rt, input int dx, input int dy, input bit cp);
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid        <= 1;
    req_type        <= rt;
    delta_x         <= 12'(dx);
    delta_y         <= 12'(dy);
    constrain_pitch <= cp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drain all results before touching registers
  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0 || out_valid) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_regs();
    int wsel;
    wsel = $urandom_range(9);
    write_reg(CFG_SENS, 16'(($urandom_range(4) == 0) ? 32'hFFFF : $urandom_range(20000)));
    if (wsel == 0) begin
      write_reg(CFG_WUP_X, 0); write_reg(CFG_WUP_Y, 0); write_reg(CFG_WUP_Z, 0);
    end else if (wsel < 4) begin
      write_reg(CFG_WUP_X, 0);
      write_reg(CFG_WUP_Y, wsel[0] ? 16'sd16384 : -16'sd16384);
      write_reg(CFG_WUP_Z, 0);
    end else begin
      write_reg(CFG_WUP_X, 16'($urandom_range(32768) - 16384));
      write_reg(CFG_WUP_Y, 16'($urandom_range(32768) - 16384));
      write_reg(CFG_WUP_Z, 16'($urandom_range(32768) - 16384));
    end
    write_reg(CFG_SYAW, 16'($urandom));
    write_reg(CFG_SPITCH, 16'($urandom));
    write_reg(CFG_SZOOM, 16'($urandom));
  endtask

  task automatic random_item();
    int  pick, dx, dy;
    pick = $urandom_range(99);
    dx = ($urandom_range(3) == 0) ? $urandom_range(4095) - 2048 : $urandom_range(80) - 40;
    dy = ($urandom_range(3) == 0) ? $urandom_range(4095) - 2048 : $urandom_range(80) - 40;
    if (pick < 55) send_item(REQ_MOVE, dx, dy, 1'($urandom_range(1)));
    else if (pick < 75)
      send_item(REQ_SCROLL, dx, ($urandom_range(4) == 0) ? dy : $urandom_range(12) - 6,
                1'($urandom_range(1)));
    else if (pick < 90) send_item(REQ_LOAD, dx, dy, 1'($urandom_range(1)));
    else send_item(REQ_NONE, dx, dy, 1'($urandom_range(1)));
  endtask

  initial begin
    rst = 1;
    in_idle = 24;
    out_idle = 80;
    in_valid = 0; req_type = REQ_MOVE; delta_x = 0; delta_y = 0; constrain_pitch = 0;
    cfg_valid = 0; cfg_index = CFG_SENS; cfg_data = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: field extremes at reset settings
    send_item(REQ_MOVE, 2047, 2047, 0);
    send_item(REQ_MOVE, -2048, -2048, 1);
    send_item(REQ_MOVE, 0, 0, 0);
    send_item(REQ_SCROLL, 0, 2047, 0);
    send_item(REQ_SCROLL, 0, -2048, 1);
    send_item(REQ_SCROLL, 0, 0, 0);
    send_item(REQ_NONE, 2047, -2048, 1);
    send_item(REQ_LOAD, -2048, 2047, 0);
    wait_drained();
    // full sensitivity: pitch clamp and wrap
    write_reg(CFG_SENS, 16'hFFFF);
    send_item(REQ_MOVE, 100, 2047, 1);
    send_item(REQ_MOVE, -100, 2047, 1);
    send_item(REQ_MOVE, 2047, -2048, 0);
    send_item(REQ_MOVE, 1, -2048, 1);
    wait_drained();
    // straight-up pitch, out-of-range load values, reversed world up
    write_reg(CFG_SPITCH, 16'd11520);
    write_reg(CFG_SYAW, 16'h7FFF);
    write_reg(CFG_SZOOM, 16'd0);
    write_reg(CFG_WUP_Y, -16'sd16384);
    send_item(REQ_LOAD, 0, 0, 0);
    wait_drained();
    write_reg(CFG_SPITCH, 16'h4000);
    write_reg(CFG_SYAW, 16'h8000);
    write_reg(CFG_SZOOM, 16'h03FF);
    send_item(REQ_LOAD, 0, 0, 0);
    wait_drained();
    write_reg(CFG_SPITCH, 16'h3FFF);
    write_reg(CFG_SYAW, -16'sd23040);
    send_item(REQ_LOAD, 0, 0, 0);
    wait_drained();
    // zero world up makes every basis degenerate
    write_reg(CFG_WUP_X, 0);
    write_reg(CFG_WUP_Y, 0);
    write_reg(CFG_WUP_Z, 0);
    write_reg(CFG_SENS, 0);
    write_reg(CFG_SPARE, 16'hFFFF);
    send_item(REQ_LOAD, 0, 0, 0);
    send_item(REQ_MOVE, 5, 5, 0);
    wait_drained();
    write_reg(CFG_WUP_X, 16'sd16384);
    write_reg(CFG_WUP_Z, -16'sd16384);
    send_item(REQ_MOVE, 0, 0, 0);

    // random phases: receiver idles, then sender idles, then neither
    for (int ph = 0; ph < 3; ph++) begin
      in_idle  = (ph == 0) ? 24 : ((ph == 1) ? 80 : 0);
      out_idle = (ph == 0) ? 80 : ((ph == 1) ? 24 : 0);
      for (int n = 0; n < 465; n++) begin
        if (n % 155 == 0) begin
          wait_drained();
          random_regs();
        end
        random_item();
      end
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
src/ecam_pkg.sv
src/ecam_sqdiv.sv
src/euler_camera_orientation.sv
verif/ecam_checker.sv
verif/testbench.sv
